>>> rtl/core/brc_pkg.sv
`default_nettype none

package brc_pkg;

   localparam int BUTTON_BITS_DEFAULT = 8;

   // round modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_COOL  = 2'd2;

   // item kinds carried on req_tuser
   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // configuration register indexes
   localparam logic CSR_ROUND_SECONDS    = 1'b0;
   localparam logic CSR_TICKS_PER_SECOND = 1'b1;

   localparam logic [8:0] ROUND_SECONDS_RESET    = 9'd10;
   localparam logic [6:0] TICKS_PER_SECOND_RESET = 7'd60;

   typedef struct packed {
      logic [8:0] round_seconds;
      logic [6:0] ticks_per_second;
   } csr_type;

   typedef struct packed {
      logic       op;
      logic [7:0] p2_before;
      logic [7:0] p2_now;
      logic [7:0] p1_before;
      logic [7:0] p1_now;
   } item_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] tick_total;
      logic        tick_step;
      logic [15:0] button_latch;
      logic [15:0] hit_total;
      logic [6:0]  subsecond_ticks;
      logic [8:0]  seconds_total;
   } state_type;

   // first member is the top bits: mode ends up lowest
   typedef struct packed {
      logic        round_over;
      logic        hit_now;
      logic [15:0] chosen_buttons;
      logic [8:0]  elapsed_seconds;
      logic [15:0] elapsed_ticks;
      logic [15:0] hits;
      logic [1:0]  mode;
   } result_type;

   // lowest newly pressed button, one-hot, or zero
   function automatic logic [7:0] first_new_press(input logic [7:0] now,
                                                  input logic [7:0] prior,
                                                  input logic [7:0] mask);
      logic [7:0] fresh;
      fresh = now & ~prior & mask;
      return fresh & (~fresh + 8'd1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/brc_step.sv
`default_nettype none

module brc_step #(
   parameter int BUTTON_BITS = brc_pkg::BUTTON_BITS_DEFAULT
) (
   input  brc_pkg::item_type   item,
   input  brc_pkg::state_type  cur,
   input  brc_pkg::csr_type    csr,
   output brc_pkg::state_type  nxt,
   output brc_pkg::result_type result
);
   import brc_pkg::*;

   localparam logic [7:0] BTN_MASK = 8'((1 << BUTTON_BITS) - 1);

   logic [15:0] pressed;
   logic [15:0] round_limit;
   logic [16:0] cool_limit;
   logic [7:0]  sub_next;
   logic        hit;
   logic        over;

   assign pressed = {first_new_press(item.p2_now, item.p2_before, BTN_MASK),
                     first_new_press(item.p1_now, item.p1_before, BTN_MASK)};
   // 7 x 9 bits never exceeds 16 bits
   assign round_limit = {9'd0, csr.ticks_per_second} * {7'd0, csr.round_seconds};
   assign cool_limit  = {9'd0, csr.ticks_per_second, 1'b0};
   assign sub_next    = {1'b0, cur.subsecond_ticks} + 8'd1;

   always_comb begin
      nxt  = cur;
      hit  = 1'b0;
      over = 1'b0;
      if (item.op == OP_TICK) begin
         nxt.tick_total = cur.tick_total + {15'd0, cur.tick_step};
         if (cur.mode == MODE_COUNT && cur.tick_step) begin
            if (sub_next >= {1'b0, csr.ticks_per_second}) begin
               nxt.subsecond_ticks = '0;
               if (cur.seconds_total != '1) begin
                  nxt.seconds_total = cur.seconds_total + 9'd1;
               end
            end else begin
               nxt.subsecond_ticks = sub_next[6:0];
            end
         end
      end else begin
         unique case (cur.mode)
            MODE_IDLE: begin
               if (pressed != '0) begin
                  nxt.hit_total       = 16'd1;
                  nxt.tick_total      = '0;
                  nxt.tick_step       = 1'b1;
                  nxt.button_latch    = pressed;
                  nxt.subsecond_ticks = '0;
                  nxt.seconds_total   = '0;
                  nxt.mode            = MODE_COUNT;
                  hit                 = 1'b1;
               end
            end
            MODE_COUNT: begin
               if ((pressed & cur.button_latch) != '0) begin
                  nxt.hit_total = cur.hit_total + 16'd1;
                  hit           = 1'b1;
               end
               if (cur.tick_total >= round_limit) begin
                  nxt.tick_step  = 1'b1;
                  nxt.tick_total = '0;
                  nxt.mode       = MODE_COOL;
                  over           = 1'b1;
               end
            end
            MODE_COOL: begin
               if ({1'b0, cur.tick_total} >= cool_limit) begin
                  nxt.mode = MODE_IDLE;
               end
            end
            default: begin
               // unreachable code: polls leave the state alone
            end
         endcase
      end
   end

   always_comb begin
      result.mode            = nxt.mode;
      result.hits            = nxt.hit_total;
      result.elapsed_ticks   = nxt.tick_total;
      result.elapsed_seconds = nxt.seconds_total;
      result.chosen_buttons  = nxt.button_latch;
      result.hit_now         = hit;
      result.round_over      = over;
   end

endmodule

`default_nettype wire

>>> rtl/core/button_press_rate_counter.sv
`default_nettype none

// channel  dir  width  contents
// req      in   32+1   tdata: p1_now, p1_before, p2_now, p2_before; tuser: op
// rsp      out  64     tdata: mode, hits, elapsed_ticks, elapsed_seconds,
//                      chosen_buttons, hit_now, round_over
// csr      in   1+1+9  write enable, register index, write data
//
// One transaction per cycle in each direction while rsp is not stalled; a
// request passes through the input register, then the result register.
// The rate is set by the combinational state update between the two registers.
// A stalled rsp holds its data; req stays ready while the input register can
// drain or is empty. Reset is synchronous and restores the power-up state
// and the default configuration.
module button_press_rate_counter #(
   parameter int BUTTON_BITS = brc_pkg::BUTTON_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] p1_now, [15:8] p1_before, [23:16] p2_now, [31:24] p2_before
   input  wire logic [31:0] req_tdata,
   // [0] op
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] mode, [17:2] hits, [33:18] elapsed_ticks, [42:34] elapsed_seconds,
   // [58:43] chosen_buttons, [59] hit_now, [60] round_over, [63:61] zero
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import brc_pkg::*;

   csr_type    csr_ff, csr_in;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       out_free;
   logic       advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROUND_SECONDS:    csr_in.round_seconds    = csr_wdata;
            CSR_TICKS_PER_SECOND: csr_in.ticks_per_second = csr_wdata[6:0];
            default:              csr_in = csr_ff;
         endcase
      end
   end

   brc_step #(
      .BUTTON_BITS(BUTTON_BITS)
   ) u_step (
      .item  (item_ff),
      .cur   (state_ff),
      .csr   (csr_ff),
      .nxt   (state_in),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.round_seconds    <= ROUND_SECONDS_RESET;
         csr_ff.ticks_per_second <= TICKS_PER_SECOND_RESET;
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff                <= '0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= {req_tuser, req_tdata[31:24], req_tdata[23:16],
                     req_tdata[15:8], req_tdata[7:0]};
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, result_ff};

`ifndef SYNTHESIS
   // the step only becomes 1 at the first round start and never drops
   a_step_before_first_round: assert property (@(posedge clock) disable iff (reset)
      !state_ff.tick_step |-> state_ff.mode == MODE_IDLE && state_ff.tick_total == '0)
      else $error("tick step clear outside the power-up idle state");

   a_round_over_enters_cool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.round_over |->
         result_ff.mode == MODE_COOL && result_ff.elapsed_ticks == '0)
      else $error("round end without cool-down and cleared ticks");

   a_hit_while_counting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.hit_now && !result_ff.round_over |->
         result_ff.mode == MODE_COUNT && result_ff.chosen_buttons != '0)
      else $error("hit reported outside a counting round");

   a_blocked_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(item_ff) && $stable(state_ff))
      else $error("pending item or state changed while the result stage was full");
`endif

endmodule

`default_nettype wire
